// ===== rtl/core/pol_pkg.sv =====
// Shared types and codes for the positional ordered list.
package pol_pkg;

  // Command codes of the input transaction.
  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_BACK  = 3'd1;
  localparam logic [2:0] CMD_INS_POS   = 3'd2;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
  localparam logic [2:0] CMD_DEL_BACK  = 3'd4;
  localparam logic [2:0] CMD_DEL_POS   = 3'd5;
  localparam logic [2:0] CMD_READ      = 3'd6;

  // Status codes of the result transaction.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BADPOS = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;

  typedef enum logic [1:0] {
    OP_INS,
    OP_DEL,
    OP_READ,
    OP_NOP
  } op_kind_e;

  typedef enum logic [1:0] {
    WH_FRONT,
    WH_BACK,
    WH_POS
  } op_where_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
    logic [5:0]         position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic [5:0]         element_index;
    logic [6:0]         count;
    logic               last;
  } out_item_t;

  // Decoded operation handed from front to back.
  typedef struct packed {
    op_kind_e           kind;
    op_where_e          where;
    logic signed [31:0] value;
    logic [5:0]         position;
  } op_t;

endpackage

// ===== rtl/core/pol_front.sv =====
// Front end: accepts input transactions and decodes them into operations.
module pol_front import pol_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output op_t      q_op_o
);

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_op_o.value    = in_item_i.value;
    q_op_o.position = in_item_i.position;
    q_op_o.where    = WH_FRONT;
    unique case (in_item_i.command)
      CMD_INS_FRONT: begin
        q_op_o.kind = OP_INS;
      end
      CMD_INS_BACK: begin
        q_op_o.kind  = OP_INS;
        q_op_o.where = WH_BACK;
      end
      CMD_INS_POS: begin
        q_op_o.kind  = OP_INS;
        q_op_o.where = WH_POS;
      end
      CMD_DEL_FRONT: begin
        q_op_o.kind = OP_DEL;
      end
      CMD_DEL_BACK: begin
        q_op_o.kind  = OP_DEL;
        q_op_o.where = WH_BACK;
      end
      CMD_DEL_POS: begin
        q_op_o.kind  = OP_DEL;
        q_op_o.where = WH_POS;
      end
      CMD_READ: begin
        q_op_o.kind = OP_READ;
      end
      default: begin
        q_op_o.kind = OP_NOP;
      end
    endcase
  end

endmodule

// ===== rtl/core/pol_fifo.sv =====
// Two-entry operation queue between front and back.
module pol_fifo import pol_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  op_t  push_op_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output op_t  op_o
);

  op_t        mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q, fill_d;

  assign full_o  = (fill_q == 2'd2);
  assign valid_o = (fill_q != 2'd0);
  assign op_o    = mem_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (push_i && !(pop_i && valid_o)) begin
      fill_d = fill_q + 2'd1;
    end else if (!push_i && pop_i && valid_o) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      fill_q <= fill_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

// ===== rtl/core/pol_back.sv =====
// Back end: cell row with parallel shift, element count and result register.
module pol_back import pol_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      op_valid_i,
  input  op_t       op_i,
  output logic      op_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int CntW = $clog2(CAPACITY + 1);

  localparam logic S_RUN  = 1'b0;
  localparam logic S_READ = 1'b1;

  logic signed [31:0] cells_q [CAPACITY];
  logic signed [31:0] cells_d [CAPACITY];
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               state_q, state_d;
  logic [6:0]         rd_idx_q, rd_idx_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;

  logic       out_free;
  logic [6:0] cnt7, pos7, slot;
  logic       ins_en, del_en, rot_en, rd_last;
  logic [1:0] st;

  assign out_free    = !out_valid_q || out_ready_i;
  assign cnt7        = 7'(cnt_q);
  assign pos7        = {1'b0, op_i.position};
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign rd_last     = (rd_idx_q == cnt7);

  // 0-based target slot of the operation
  always_comb begin
    unique case (op_i.where)
      WH_FRONT: slot = 7'd0;
      WH_BACK:  slot = (op_i.kind == OP_INS) ? cnt7 : cnt7 - 7'd1;
      WH_POS:   slot = pos7 - 7'd1;
      default:  slot = 7'd0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    op_pop_o    = 1'b0;
    ins_en      = 1'b0;
    del_en      = 1'b0;
    rot_en      = 1'b0;
    st          = ST_OK;

    unique case (state_q)
      S_RUN: begin
        if (op_valid_i && out_free) begin
          op_pop_o = 1'b1;
          unique case (op_i.kind)
            OP_INS: begin
              priority if (op_i.where == WH_POS &&
                           (pos7 == 7'd0 || pos7 > cnt7 + 7'd1)) begin
                st = ST_BADPOS;
              end else if (cnt7 >= 7'(CAPACITY)) begin
                st = ST_FULL;
              end else begin
                ins_en = 1'b1;
                cnt_d  = cnt_q + CntW'(1);
              end
            end
            OP_DEL: begin
              priority if (cnt7 == 7'd0) begin
                st = ST_EMPTY;
              end else if (op_i.where == WH_POS &&
                           (pos7 == 7'd0 || pos7 > cnt7)) begin
                st = ST_BADPOS;
              end else begin
                del_en = 1'b1;
                cnt_d  = cnt_q - CntW'(1);
              end
            end
            OP_READ: begin
              if (cnt7 == 7'd0) begin
                st = ST_EMPTY;
              end
            end
            default: begin
              st = ST_OK;
            end
          endcase

          if (op_i.kind == OP_READ && cnt7 != 7'd0) begin
            // stream starts in S_READ once the result register is free
            state_d  = S_READ;
            rd_idx_d = 7'd1;
          end else begin
            out_valid_d         = 1'b1;
            out_d.status        = st;
            out_d.element       = '0;
            out_d.element_index = '0;
            out_d.count         = 7'(cnt_d);
            out_d.last          = 1'b1;
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          rot_en              = 1'b1;
          out_valid_d         = 1'b1;
          out_d.status        = ST_OK;
          out_d.element       = cells_q[0];
          out_d.element_index = rd_idx_q[5:0];
          out_d.count         = cnt7;
          out_d.last          = rd_last;
          rd_idx_d            = rd_idx_q + 7'd1;
          if (rd_last) begin
            state_d = S_RUN;
          end
        end
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  // Per-cell next value: insert shifts up, delete shifts down, read rotates
  // the live part of the row so cell 0 always holds the next element.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_d[i] = cells_q[i];
      if (ins_en) begin
        if (7'(i) == slot) begin
          cells_d[i] = op_i.value;
        end else if (7'(i) > slot) begin
          cells_d[i] = cells_q[(i + CAPACITY - 1) % CAPACITY];
        end
      end else if (del_en) begin
        if (7'(i) >= slot && i + 1 < CAPACITY) begin
          cells_d[i] = cells_q[(i + 1) % CAPACITY];
        end
      end else if (rot_en) begin
        cells_d[i] = (7'(i) + 7'd1 == cnt7) ? cells_q[0] : cells_q[(i + 1) % CAPACITY];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RUN;
      cnt_q       <= '0;
      rd_idx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_idx_q    <= rd_idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    cells_q <= cells_d;
  end

endmodule

// ===== rtl/core/positional_ordered_list.sv =====
// Top level of the positional ordered list.
//
// Holds up to CAPACITY signed 32-bit values in order. Each input transaction
// (in_valid_i / in_ready_o / in_item_i) carries one command: insert at the
// front, back or a 1-based position, delete at the front, back or a position,
// or read out the whole list. Results leave on out_valid_o / out_ready_i /
// out_item_o, and every result carries the element count after the command.
//
// The front decodes commands into a two-entry queue; the back owns the cell
// row and the count. Insert and delete shift all cells at once, so the back
// retires one such command per cycle while the result register is free, and
// its single result is valid the cycle after the back picks it up. A read out
// first enters its read state, then streams one element per cycle while the
// receiver is ready, front first, by rotating the live cells; it occupies the
// back until the last element. An empty read out gives one list-empty result.
//
// Reset clears the count, the queue and the result valid flag; stored values
// are not cleared and are never shown before being written. When the receiver
// stalls, the result register holds, the back stops, and the front keeps
// taking commands until the queue is full, then drops in_ready_o.
module positional_ordered_list import pol_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic q_push, q_full, q_pop, q_valid;
  op_t  q_in_op, q_out_op;

  pol_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_op_o     (q_in_op)
  );

  pol_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_op_i (q_in_op),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .op_o      (q_out_op)
  );

  pol_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (q_valid),
    .op_i        (q_out_op),
    .op_pop_o    (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
